/* hw/rtl/vector4_normalize_assert.svh */
// Assertion macros for the vector4_normalize checker.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef VECTOR4_NORMALIZE_ASSERT_SVH
`define VECTOR4_NORMALIZE_ASSERT_SVH

// checked outside reset
`define VN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset too
`define VN_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/vnorm_pkg.sv */
// Shared constants and types for the vector normalizer.
// No dependencies.
package vnorm_pkg;

    localparam int LANES      = 4;
    localparam int IN_PORT_W  = 32;
    localparam int OUT_W      = 18;
    localparam int NORM_SHIFT = 34;
    localparam int QUOT_W     = NORM_SHIFT + 1;
    localparam int ROOT_W     = 18;

    typedef struct packed {
        logic             zero;
        logic [LANES-1:0] neg;
    } t_side;

endpackage

/* hw/rtl/vector4_normalize.sv */
// Four-component vector normalizer, Q16.16 in, Q2.16 out, fully pipelined.
// Depends on vnorm_pkg.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+---------------------------------------------
//  in      | i_valid | o_stall | i_x_in i_y_in i_z_in i_w_in
//  out     | o_valid | i_stall | o_x_out o_y_out o_z_out o_w_out o_zero_length
//
// One transaction per cycle while the output is not stalled. Stages: 4 for
// magnitude, squares and sum, 35 for the bit-per-stage restoring divide
// (2^34 c^2 / S), 18 for the bit-pair square root, 1 for rounding and sign.
// Reset clears only the valid bits. A stall at a valid output freezes the
// whole pipeline; nothing is dropped or repeated.
module vector4_normalize #(
    parameter int INPUT_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [vnorm_pkg::IN_PORT_W-1:0] i_x_in,
    input  logic [vnorm_pkg::IN_PORT_W-1:0] i_y_in,
    input  logic [vnorm_pkg::IN_PORT_W-1:0] i_z_in,
    input  logic [vnorm_pkg::IN_PORT_W-1:0] i_w_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [vnorm_pkg::OUT_W-1:0]     o_x_out,
    output logic [vnorm_pkg::OUT_W-1:0]     o_y_out,
    output logic [vnorm_pkg::OUT_W-1:0]     o_z_out,
    output logic [vnorm_pkg::OUT_W-1:0]     o_w_out,
    output logic                           o_zero_length
);
    import vnorm_pkg::*;

    localparam int MW  = INPUT_WIDTH;
    localparam int PW  = 2 * MW;
    localparam int SW  = PW + 1;
    localparam int RW  = SW + 1;
    localparam int SRW = ROOT_W + 3;
    localparam int DW  = 2 * ROOT_W;
    localparam int NST = 4 + QUOT_W + ROOT_W + 1;

    logic                 en;
    logic [IN_PORT_W-1:0] in_c [LANES];

    logic  r_v    [1:NST];
    t_side r_side [1:NST];
    t_side n_side;

    logic [MW-1:0] n_mag [LANES];
    logic [MW-1:0] r_mag [LANES];
    logic [PW-1:0] r_sq  [LANES];
    logic [PW-1:0] r_c2  [LANES];
    logic [SW-1:0] r_p01;
    logic [SW-1:0] r_p23;

    logic [RW-1:0]     r_drem [0:QUOT_W-1][LANES];
    logic [SW-1:0]     r_dsum [0:QUOT_W-1];
    logic [QUOT_W-1:0] r_dquo [1:QUOT_W][LANES];

    logic [DW-1:0]     r_sdat  [1:ROOT_W-1][LANES];
    logic [SRW-1:0]    r_srem  [1:ROOT_W-1][LANES];
    logic [ROOT_W-1:0] r_sroot [1:ROOT_W][LANES];

    logic [ROOT_W:0]  rnd   [LANES];
    logic [OUT_W-1:0] n_out [LANES];
    logic [OUT_W-1:0] r_out [LANES];

    assign in_c[0] = i_x_in;
    assign in_c[1] = i_y_in;
    assign in_c[2] = i_z_in;
    assign in_c[3] = i_w_in;

    assign o_stall = r_v[NST] & i_stall;
    assign en      = ~o_stall;

    // valid and side info travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NST; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[1] <= i_valid;
            for (int k = 2; k <= NST; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1] <= n_side;
            for (int k = 2; k <= NST; k++) r_side[k] <= r_side[k-1];
        end
    end

    // stage 1: magnitudes
    always_comb begin
        n_side.zero = 1'b1;
        for (int l = 0; l < LANES; l++) begin
            n_side.neg[l] = in_c[l][MW-1];
            n_mag[l]      = in_c[l][MW-1] ? (~in_c[l][MW-1:0] + 1'b1) : in_c[l][MW-1:0];
            if (in_c[l][MW-1:0] != '0) n_side.zero = 1'b0;
        end
    end

    // stages 1-4: magnitude, square, pair sums, total
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                r_mag[l]     <= n_mag[l];
                r_sq[l]      <= PW'(r_mag[l]) * PW'(r_mag[l]);
                r_c2[l]      <= r_sq[l];
                r_drem[0][l] <= RW'(r_c2[l]);
            end
            r_p01     <= SW'(r_sq[0]) + SW'(r_sq[1]);
            r_p23     <= SW'(r_sq[2]) + SW'(r_sq[3]);
            r_dsum[0] <= r_p01 + r_p23;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < QUOT_W; j++) begin : g_div
        logic [RW-1:0]     d_t  [LANES];
        logic [QUOT_W-1:0] d_q  [LANES];
        logic              d_ge [LANES];

        if (j == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    d_t[l] = r_drem[j][l];
                    d_q[l] = '0;
                end
            end
        end else begin : g_rest
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    d_t[l] = {r_drem[j][l][RW-2:0], 1'b0};
                    d_q[l] = r_dquo[j][l];
                end
            end
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) d_ge[l] = d_t[l] >= RW'(r_dsum[j]);
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int l = 0; l < LANES; l++) begin
                    r_dquo[j+1][l] <= {d_q[l][QUOT_W-2:0], d_ge[l]};
                end
            end
        end

        if (j < QUOT_W - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dsum[j+1] <= r_dsum[j];
                    for (int l = 0; l < LANES; l++) begin
                        r_drem[j+1][l] <= d_ge[l] ? (d_t[l] - RW'(r_dsum[j])) : d_t[l];
                    end
                end
            end
        end
    end

    // integer square root, one root bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [DW-1:0]     a_dat  [LANES];
        logic [SRW-1:0]    a_rem  [LANES];
        logic [ROOT_W-1:0] a_root [LANES];
        logic [SRW-1:0]    s_t    [LANES];
        logic [SRW-1:0]    s_trl  [LANES];
        logic              s_ge   [LANES];

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    a_dat[l]  = DW'(r_dquo[QUOT_W][l]);
                    a_rem[l]  = '0;
                    a_root[l] = '0;
                end
            end
        end else begin : g_rest
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    a_dat[l]  = r_sdat[k][l];
                    a_rem[l]  = r_srem[k][l];
                    a_root[l] = r_sroot[k][l];
                end
            end
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                s_t[l]   = {a_rem[l][SRW-3:0], a_dat[l][DW-1 -: 2]};
                s_trl[l] = SRW'({a_root[l], 2'b01});
                s_ge[l]  = s_t[l] >= s_trl[l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int l = 0; l < LANES; l++) begin
                    r_sroot[k+1][l] <= {a_root[l][ROOT_W-2:0], s_ge[l]};
                end
            end
        end

        if (k < ROOT_W - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (en) begin
                    for (int l = 0; l < LANES; l++) begin
                        r_srem[k+1][l] <= s_ge[l] ? (s_t[l] - s_trl[l]) : s_t[l];
                        r_sdat[k+1][l] <= {a_dat[l][DW-3:0], 2'b00};
                    end
                end
            end
        end
    end

    // q = (isqrt + 1) / 2, then sign
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            rnd[l] = {1'b0, r_sroot[ROOT_W][l]} + 1'b1;
            if (r_side[NST-1].zero) begin
                n_out[l] = '0;
            end else if (r_side[NST-1].neg[l]) begin
                n_out[l] = ~OUT_W'(rnd[l][ROOT_W:1]) + 1'b1;
            end else begin
                n_out[l] = OUT_W'(rnd[l][ROOT_W:1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) r_out[l] <= n_out[l];
        end
    end

    assign o_valid       = r_v[NST];
    assign o_zero_length = r_side[NST].zero;
    assign o_x_out       = r_out[0];
    assign o_y_out       = r_out[1];
    assign o_z_out       = r_out[2];
    assign o_w_out       = r_out[3];

endmodule

/* hw/rtl/vnorm_checker.sv */
// Port-level checks for vector4_normalize, bound to the top level.
// Depends on vnorm_pkg and vector4_normalize_assert.svh.
`include "vector4_normalize_assert.svh"

module vnorm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [vnorm_pkg::IN_PORT_W-1:0] i_x_in,
    input logic [vnorm_pkg::IN_PORT_W-1:0] i_y_in,
    input logic [vnorm_pkg::IN_PORT_W-1:0] i_z_in,
    input logic [vnorm_pkg::IN_PORT_W-1:0] i_w_in,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [vnorm_pkg::OUT_W-1:0]     o_x_out,
    input logic [vnorm_pkg::OUT_W-1:0]     o_y_out,
    input logic [vnorm_pkg::OUT_W-1:0]     o_z_out,
    input logic [vnorm_pkg::OUT_W-1:0]     o_w_out,
    input logic                           o_zero_length
);
    import vnorm_pkg::*;

    `VN_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_x_out) && $stable(o_w_out) && $stable(o_zero_length), "stalled transaction changed")
    `VN_ASSERT(a_stall_src, o_stall |-> o_valid && i_stall, "input stalled with free output")
    `VN_ASSERT(a_zero_out, o_valid && o_zero_length |-> o_x_out == '0 && o_y_out == '0 && o_z_out == '0 && o_w_out == '0, "zero vector gave nonzero result")
    `VN_ASSERT(a_unit_range, o_valid |-> $signed(o_x_out) <= 18'sd65536 && $signed(o_x_out) >= -18'sd65536 && $signed(o_w_out) <= 18'sd65536 && $signed(o_w_out) >= -18'sd65536, "component beyond unit")
    `VN_ASSERT_RST(a_rst_idle, !i_rst_n |=> !o_valid, "valid out of reset")

endmodule

bind vector4_normalize vnorm_checker u_vnorm_checker (.*);

/* bench/vector4_normalize_tb.sv */
// Self-checking bench for vector4_normalize: random and corner-case vectors,
// expected unit vectors computed by an exact search, random stall and idle.
// Depends on vnorm_pkg and the vector4_normalize RTL.
`timescale 1ns / 100ps

module vector4_normalize_tb;
    import vnorm_pkg::*;

    localparam int IN_W = 32;
    localparam int N_RANDOM = 1630;
    localparam int LATENCY = 58;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [IN_W-1:0] x;
        logic [IN_W-1:0] y;
        logic [IN_W-1:0] z;
        logic [IN_W-1:0] w;
    } t_vec;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
        logic [OUT_W-1:0] w;
        logic             zero;
    } t_unit;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic [IN_PORT_W-1:0] i_x_in, i_y_in, i_z_in, i_w_in;
    logic o_valid;
    logic i_stall;
    logic [OUT_W-1:0] o_x_out, o_y_out, o_z_out, o_w_out;
    logic o_zero_length;

    t_vec   pending_vecs[$];
    t_unit  expected_units[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_cycles;
    bit     stim_done;
    int     mismatches;
    longint cycle_count;

    vector4_normalize #(.INPUT_WIDTH(IN_W)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_x_in(i_x_in), .i_y_in(i_y_in), .i_z_in(i_z_in), .i_w_in(i_w_in),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_x_out(o_x_out), .o_y_out(o_y_out), .o_z_out(o_z_out), .o_w_out(o_w_out),
        .o_zero_length(o_zero_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] abs_of(logic [IN_W-1:0] v);
        logic [IN_W-1:0] m;
        m = v[IN_W-1] ? (~v + 1'b1) : v;
        return 64'(m);
    endfunction

    // largest q in 0..65536 with q == 0 or (2q-1)^2 * S <= 2^34 * c^2
    function automatic logic [OUT_W-1:0] unit_component(logic [IN_W-1:0] c,
                                                         logic [129:0] sumsq);
        logic [63:0]  mag;
        logic [129:0] rhs;
        logic [129:0] lhs;
        logic [63:0]  odd;
        int lo, hi, mid;
        mag = abs_of(c);
        rhs = 130'(mag * mag) << 34;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 64'(2 * mid - 1);
            lhs = 130'(odd * odd) * sumsq;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return c[IN_W-1] ? OUT_W'(-lo) : OUT_W'(lo);
    endfunction

    function automatic t_unit normalize(t_vec v);
        t_unit r;
        logic [129:0] s;
        s = 130'(abs_of(v.x) * abs_of(v.x)) + 130'(abs_of(v.y) * abs_of(v.y))
          + 130'(abs_of(v.z) * abs_of(v.z)) + 130'(abs_of(v.w) * abs_of(v.w));
        if (s == 0) begin
            r = '0;
            r.zero = 1'b1;
        end else begin
            r.x = unit_component(v.x, s);
            r.y = unit_component(v.y, s);
            r.z = unit_component(v.z, s);
            r.w = unit_component(v.w, s);
            r.zero = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [IN_W-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return IN_W'($signed($urandom_range(0, 2000)) - 1000);
            4: return IN_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_vec(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                           logic [IN_W-1:0] z, logic [IN_W-1:0] w);
        t_vec v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.w = w;
        pending_vecs.push_back(v);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) void'(pending_vecs.pop_front());
            if (i_valid && o_stall) begin
                // hold payload
            end else if (pending_vecs.size() > 0
                         && $urandom_range(0, 99) >= send_idle_pct) begin
                t_vec nv;
                nv = pending_vecs[0];
                i_valid <= 1'b1;
                i_x_in <= nv.x;
                i_y_in <= nv.y;
                i_z_in <= nv.z;
                i_w_in <= nv.w;
                expected_units.push_back(normalize(nv));
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a single long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_unit got, want;
            got = {o_x_out, o_y_out, o_z_out, o_w_out, o_zero_length};
            if (expected_units.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected transaction %h", got);
            end else begin
                want = expected_units.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch exp x=%h y=%h z=%h w=%h zl=%b got x=%h y=%h z=%h w=%h zl=%b",
                                 want.x, want.y, want.z, want.w, want.zero,
                                 got.x, got.y, got.z, got.w, got.zero);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_x_in = '0;
        i_y_in = '0;
        i_z_in = '0;
        i_w_in = '0;
        send_idle_pct = 12;
        recv_idle_pct = 48;
        hold_cycles = 0;
        stim_done = 1'b0;
        mismatches = 0;
        cycle_count = 0;

        add_vec(0, 0, 0, 0);
        add_vec(32'h0001_0000, 0, 0, 0);
        add_vec(0, 32'hFFFF_0000, 0, 0);
        add_vec(0, 0, 32'h8000_0000, 0);
        add_vec(0, 0, 0, 32'h7FFF_FFFF);
        add_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        add_vec(1, 1, 1, 1);
        add_vec(32'hFFFF_FFFF, 0, 0, 0);
        add_vec(1, 32'h7FFF_FFFF, 0, 0);
        add_vec(3, 4, 0, 0);
        add_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_vec(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        add_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_RANDOM; i++)
            add_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp());

        wait (pending_vecs.size() < 1100);
        @(posedge i_clk);
        hold_cycles <= 300;
        wait (pending_vecs.size() < 1000);
        @(posedge i_clk);
        send_idle_pct = 48;
        recv_idle_pct = 12;
        wait (pending_vecs.size() < 500);
        @(posedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (pending_vecs.size() == 0);
        wait (expected_units.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_units.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
